// ===== sv/m3i_pkg.sv =====
// Package: shared types, constants and index tables for the 3x3 matrix inverse pipeline.
package m3i_pkg;

  localparam int N_EL      = 9;
  localparam int N_PROD    = 2 * N_EL;
  localparam int N_ROW     = 3;
  // quotient bits resolved by the divider, one per stage
  localparam int DIV_STEPS = 33;
  // numerator is the cofactor shifted left by this many bits
  localparam int NUM_SHIFT = 28;
  // cofactor bits that enter the divider one per stage
  localparam int C_LOW     = DIV_STEPS - NUM_SHIFT;

  typedef logic signed [15:0] elem_t;
  typedef logic signed [31:0] prod_t;
  typedef logic signed [32:0] adj_t;
  typedef logic signed [47:0] dprod_t;
  typedef logic signed [49:0] det_t;
  typedef logic        [47:0] dmag_t;
  typedef logic        [32:0] quo_t;
  typedef logic signed [31:0] res_t;

  localparam res_t RES_MAX = 32'sh7FFF_FFFF;
  localparam res_t RES_MIN = 32'sh8000_0000;
  localparam quo_t QUO_POS_LIMIT = 33'h0_7FFF_FFFF;
  localparam quo_t QUO_NEG_LIMIT = 33'h0_8000_0000;

  // Operand indices of the cofactor products; cofactor k = p[2k] - p[2k+1].
  // Element index is row * 3 + column.
  localparam int PA [N_PROD] = '{4, 5, 5, 3, 3, 4, 7, 8, 8, 6, 6, 7, 1, 2, 2, 0, 0, 1};
  localparam int PB [N_PROD] = '{8, 7, 6, 8, 7, 6, 2, 1, 0, 2, 1, 0, 5, 4, 3, 5, 4, 3};

  // State of the nine divider lanes plus the shared determinant.
  typedef struct packed {
    dmag_t [N_EL-1:0]            rem;
    quo_t  [N_EL-1:0]            quo;
    logic  [N_EL-1:0][C_LOW-1:0] clo;
    logic  [N_EL-1:0]            neg;
    logic  [N_EL-1:0]            ovf;
    dmag_t                       dabs;
    det_t                        det;
    logic                        singular;
  } div_t;

endpackage

// ===== sv/m3i_if.sv =====
// Interfaces: matrix input channel and inverse result channel.
interface m3i_in_if;
  import m3i_pkg::*;
  logic  valid;
  logic  ready;
  elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface m3i_out_if;
  import m3i_pkg::*;
  logic valid;
  logic ready;
  res_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  det_t determinant;
  logic singular;
  logic saturated;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  determinant, singular, saturated, input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  determinant, singular, saturated, output ready);
endinterface

// ===== sv/m3i_adj.sv =====
// Adjugate stages: cofactor products, then cofactor differences.
module m3i_adj
  import m3i_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  elem_t m   [N_EL],
  output logic  adj_vld,
  output adj_t  adj [N_EL],
  output elem_t row0 [N_ROW]
);

  logic  v1_r, v2_r;
  prod_t p_r    [N_PROD];
  elem_t r0a_r  [N_ROW];
  adj_t  a_r    [N_EL];
  elem_t r0b_r  [N_ROW];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  // stage 1: the eighteen 16x16 products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_PROD; i++) begin
        p_r[i] <= m[PA[i]] * m[PB[i]];
      end
      for (int i = 0; i < N_ROW; i++) begin
        r0a_r[i] <= m[i];
      end
    end
  end

  // stage 2: cofactors as product differences
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_EL; i++) begin
        a_r[i] <= adj_t'(p_r[2*i]) - adj_t'(p_r[2*i+1]);
      end
      r0b_r <= r0a_r;
    end
  end

  assign adj_vld = v2_r;
  assign adj     = a_r;
  assign row0    = r0b_r;

endmodule

// ===== sv/m3i_det.sv =====
// Determinant stages and divider operand preparation.
module m3i_det
  import m3i_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  adj_vld,
  input  adj_t  adj  [N_EL],
  input  elem_t row0 [N_ROW],
  output logic  div_vld,
  output div_t  div_o
);

  logic   v3_r, v4_r, v5_r;
  dprod_t dp_r [N_ROW];
  adj_t   a3_r [N_EL];
  adj_t   a4_r [N_EL];
  det_t   d_r;
  div_t   div_r;
  div_t   div_nxt;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v3_r <= adj_vld;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // stage 3: first cofactor row times first matrix row
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_ROW; i++) begin
        dp_r[i] <= dprod_t'(adj[i]) * dprod_t'(row0[i]);
      end
      a3_r <= adj;
    end
  end

  // stage 4: determinant sum
  always_ff @(posedge clk) begin
    if (en) begin
      d_r  <= det_t'(dp_r[0]) + det_t'(dp_r[1]) + det_t'(dp_r[2]);
      a4_r <= a3_r;
    end
  end

  // stage 5: magnitudes, signs, first partial remainder and overflow check
  always_comb begin
    logic [31:0] cabs;
    logic [26:0] rtop;
    div_nxt          = '0;
    div_nxt.det      = d_r;
    div_nxt.singular = (d_r == '0);
    div_nxt.dabs     = d_r[49] ? dmag_t'(-d_r) : dmag_t'(d_r);
    for (int i = 0; i < N_EL; i++) begin
      cabs            = a4_r[i][32] ? 32'(-a4_r[i]) : a4_r[i][31:0];
      rtop            = cabs[31:C_LOW];
      div_nxt.rem[i]  = dmag_t'(rtop);
      div_nxt.clo[i]  = cabs[C_LOW-1:0];
      div_nxt.neg[i]  = a4_r[i][32] ^ d_r[49];
      div_nxt.ovf[i]  = (dmag_t'(rtop) >= div_nxt.dabs);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

  assign div_vld = v5_r;
  assign div_o   = div_r;

endmodule

// ===== sv/m3i_div.sv =====
// Restoring divider pipeline: one quotient bit per stage across nine lanes.
module m3i_div
  import m3i_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic div_vld,
  input  div_t div_i,
  output logic quo_vld,
  output div_t quo_o
);

  div_t stg_r [DIV_STEPS];
  logic vld_r [DIV_STEPS];
  div_t src   [DIV_STEPS];
  logic src_v [DIV_STEPS];

  assign src[0]   = div_i;
  assign src_v[0] = div_vld;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    // numerator bit brought down at this step
    localparam int BITPOS = DIV_STEPS - 1 - k;
    logic [N_EL-1:0] bit_in;
    div_t            stg_nxt;

    if (k > 0) begin : g_link
      assign src[k]   = stg_r[k-1];
      assign src_v[k] = vld_r[k-1];
    end

    if (BITPOS >= NUM_SHIFT) begin : g_cbit
      for (genvar l = 0; l < N_EL; l++) begin : g_lane
        assign bit_in[l] = src[k].clo[l][BITPOS-NUM_SHIFT];
      end
    end else begin : g_zero
      assign bit_in = '0;
    end

    // compare-subtract per lane
    always_comb begin
      logic [48:0] trial;
      stg_nxt = src[k];
      for (int l = 0; l < N_EL; l++) begin
        trial = {src[k].rem[l], bit_in[l]};
        if (trial >= {1'b0, src[k].dabs}) begin
          stg_nxt.rem[l] = dmag_t'(trial - {1'b0, src[k].dabs});
          stg_nxt.quo[l] = {src[k].quo[l][31:0], 1'b1};
        end else begin
          stg_nxt.rem[l] = trial[47:0];
          stg_nxt.quo[l] = {src[k].quo[l][31:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k] <= stg_nxt;
      end
    end
  end

  assign quo_vld = vld_r[DIV_STEPS-1];
  assign quo_o   = stg_r[DIV_STEPS-1];

endmodule

// ===== sv/m3i_out.sv =====
// Output stage: sign, saturation, singular handling and transpose into the result register.
module m3i_out
  import m3i_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic quo_vld,
  input  div_t quo_i,
  output logic out_vld,
  output res_t res [N_EL],
  output det_t det,
  output logic singular,
  output logic saturated
);

  logic out_vld_r;
  res_t res_r [N_EL];
  res_t res_nxt [N_EL];
  det_t det_r;
  logic sing_r;
  logic sat_r, sat_nxt;

  // result element (i, j) comes from cofactor lane (j, i)
  always_comb begin
    int lane;
    sat_nxt = 1'b0;
    for (int i = 0; i < N_ROW; i++) begin
      for (int j = 0; j < N_ROW; j++) begin
        lane = j * N_ROW + i;
        if (quo_i.singular) begin
          res_nxt[i*N_ROW+j] = '0;
        end else if (!quo_i.neg[lane]) begin
          if (quo_i.ovf[lane] || quo_i.quo[lane] > QUO_POS_LIMIT) begin
            res_nxt[i*N_ROW+j] = RES_MAX;
            sat_nxt            = 1'b1;
          end else begin
            res_nxt[i*N_ROW+j] = res_t'(quo_i.quo[lane]);
          end
        end else begin
          if (quo_i.ovf[lane] || quo_i.quo[lane] > QUO_NEG_LIMIT) begin
            res_nxt[i*N_ROW+j] = RES_MIN;
            sat_nxt            = 1'b1;
          end else begin
            res_nxt[i*N_ROW+j] = res_t'(-quo_i.quo[lane]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= quo_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      det_r  <= quo_i.det;
      sing_r <= quo_i.singular;
      sat_r  <= sat_nxt;
    end
  end

  assign out_vld   = out_vld_r;
  assign res       = res_r;
  assign det       = det_r;
  assign singular  = sing_r;
  assign saturated = sat_r;

  // singular result carries zero determinant, zero diagonal elements and no clamp
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && sing_r |-> det_r == '0 && !sat_r && res_r[0] == '0 && res_r[4] == '0
                            && res_r[8] == '0)
    else $error("singular result not cleared");

  // a regular result has a nonzero determinant
  a_det_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !sing_r |-> det_r != '0)
    else $error("zero determinant without singular flag");

  // the clamp flag implies some element sits at a range limit
  a_sat_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && sat_r |-> res_r[0] == RES_MAX || res_r[0] == RES_MIN
      || res_r[1] == RES_MAX || res_r[1] == RES_MIN || res_r[2] == RES_MAX
      || res_r[2] == RES_MIN || res_r[3] == RES_MAX || res_r[3] == RES_MIN
      || res_r[4] == RES_MAX || res_r[4] == RES_MIN || res_r[5] == RES_MAX
      || res_r[5] == RES_MIN || res_r[6] == RES_MAX || res_r[6] == RES_MIN
      || res_r[7] == RES_MAX || res_r[7] == RES_MIN || res_r[8] == RES_MAX
      || res_r[8] == RES_MIN)
    else $error("saturated flag without clamped element");

endmodule

// ===== sv/matrix3_inverse_top.sv =====
// Top level: 3x3 fixed-point matrix inverse by adjugate and pipelined division.
//
// Input channel in_ch carries one 3x3 matrix of signed Q4.12 elements per
// transaction; output channel out_ch carries the inverse in signed Q16.16,
// truncated toward zero and clamped to 32 bits, plus the exact 50-bit
// determinant, a singular flag and a saturated flag.
// From input transaction to result valid the data passes two adjugate
// stages, three determinant/prep stages, 33 divider stages (one quotient bit
// each, nine lanes sharing the determinant) and the output register.
// Throughput is one matrix per cycle while results are taken; the divider stage chain sets the depth.
// A zero determinant gives zero elements, singular high, saturated low.
// Reset clears the valid bits of every stage; no result is pending after it.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ch.ready drops; nothing is lost or repeated, and the flow resumes
// in the cycle the result is taken.
module matrix3_inverse_top
  import m3i_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  m3i_in_if.sink     in_ch,
  m3i_out_if.source  out_ch
);

  logic  en;
  logic  adj_vld, div_vld, quo_vld, out_vld;
  elem_t m    [N_EL];
  adj_t  adj  [N_EL];
  elem_t row0 [N_ROW];
  div_t  div_s, quo_s;
  res_t  res  [N_EL];

  // pipeline advances unless a finished result is blocked
  assign en          = !out_vld || out_ch.ready;
  assign in_ch.ready = en;

  assign m[0] = in_ch.m00;
  assign m[1] = in_ch.m01;
  assign m[2] = in_ch.m02;
  assign m[3] = in_ch.m10;
  assign m[4] = in_ch.m11;
  assign m[5] = in_ch.m12;
  assign m[6] = in_ch.m20;
  assign m[7] = in_ch.m21;
  assign m[8] = in_ch.m22;

  m3i_adj u_adj (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_ch.valid),
    .m       (m),
    .adj_vld (adj_vld),
    .adj     (adj),
    .row0    (row0)
  );

  m3i_det u_det (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .adj_vld (adj_vld),
    .adj     (adj),
    .row0    (row0),
    .div_vld (div_vld),
    .div_o   (div_s)
  );

  m3i_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .div_vld (div_vld),
    .div_i   (div_s),
    .quo_vld (quo_vld),
    .quo_o   (quo_s)
  );

  m3i_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .quo_vld   (quo_vld),
    .quo_i     (quo_s),
    .out_vld   (out_vld),
    .res       (res),
    .det       (out_ch.determinant),
    .singular  (out_ch.singular),
    .saturated (out_ch.saturated)
  );

  assign out_ch.valid = out_vld;
  assign out_ch.r00   = res[0];
  assign out_ch.r01   = res[1];
  assign out_ch.r02   = res[2];
  assign out_ch.r10   = res[3];
  assign out_ch.r11   = res[4];
  assign out_ch.r12   = res[5];
  assign out_ch.r20   = res[6];
  assign out_ch.r21   = res[7];
  assign out_ch.r22   = res[8];

endmodule
